### hw/rtl/skf_pkg.sv
`default_nettype none

package skf_pkg;

    localparam int DATA_W   = 32;
    localparam int GAIN_W   = 17;
    localparam int FRAC_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int MCAND_W  = DATA_W + 2;
    localparam int PROD_W   = MCAND_W + 2;
    localparam int CNT_W    = 5;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << FRAC_W);
    localparam logic [DATA_W-1:0] NOISE_RESET = DATA_W'(6554);
    localparam logic [CNT_W-1:0]  LAST_STEP = CNT_W'(GAIN_W - 1);

    localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROCESS_NOISE = 2'd0,
        REG_MEASURE_NOISE = 2'd1
    } cfg_reg_t;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PREP  = 7'b0000010,
        S_DIVGO = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_MULGO = 7'b0010000,
        S_MUL   = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

### hw/rtl/scalar_kalman_filter.sv
// Steps from input beat to result valid: prior sums, divider load, bit-serial gain
// divide, gain capture, multiplier load, two shift-add multiplies side by side,
// write-back.
// Flow: one item at a time; write-back holds while the previous result is still unread,
// and the input waits with it.
// Reset: asynchronous, active low; estimate and covariance clear, noise registers to 6554.
`default_nettype none

module scalar_kalman_filter
    import skf_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [DATA_W-1:0] measurement,
    input  wire logic signed [DATA_W-1:0] predicted_step,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [DATA_W-1:0]      estimate,
    output logic [GAIN_W-1:0]             kalman_gain,
    output logic                          saturated,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [DATA_W-1:0]        cfg_data
);

    state_t                    state_reg, state_next;
    logic [DATA_W-1:0]         q_reg, r_reg;
    logic signed [DATA_W-1:0]  est_reg;
    logic [DATA_W-1:0]         cov_reg;
    logic signed [DATA_W-1:0]  z_reg, step_reg;
    logic signed [DATA_W-1:0]  prior_reg;
    logic [DATA_W-1:0]         pp_reg;
    logic                      sat_reg;
    logic [GAIN_W-1:0]         k_reg;
    logic                      out_valid_reg;
    logic signed [DATA_W-1:0]  out_est_reg;
    logic [GAIN_W-1:0]         out_gain_reg;
    logic                      out_sat_reg;

    logic                      in_fire, out_fire, fin_go;
    logic signed [DATA_W:0]    prior_sum;
    logic                      prior_ovf;
    logic signed [DATA_W-1:0]  prior_clamp;
    logic [DATA_W:0]           pp_sum;
    logic [DATA_W-1:0]         pp_clamp;
    logic signed [MCAND_W-1:0] innov;
    logic signed [MCAND_W-1:0] pp_mcand;
    logic [GAIN_W-1:0]         one_minus_k;
    logic                      div_start, div_done;
    logic [GAIN_W-1:0]         div_quo;
    logic                      mul_start, mul_e_done, mul_p_done;
    logic signed [PROD_W-1:0]  delta, cov_prod;
    logic signed [PROD_W-1:0]  est_sum;
    logic                      est_hi, est_lo;
    logic signed [DATA_W-1:0]  est_clamp;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid & in_ready;
    assign out_fire  = out_valid_reg & out_ready;
    assign fin_go    = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    assign prior_sum   = {est_reg[DATA_W-1], est_reg} + {step_reg[DATA_W-1], step_reg};
    assign prior_ovf   = prior_sum[DATA_W] != prior_sum[DATA_W-1];
    assign prior_clamp = !prior_ovf ? prior_sum[DATA_W-1:0]
                       : (prior_sum[DATA_W] ? S32_MIN : S32_MAX);
    assign pp_sum      = {1'b0, cov_reg} + {1'b0, q_reg};
    assign pp_clamp    = pp_sum[DATA_W] ? '1 : pp_sum[DATA_W-1:0];

    assign innov       = {{2{z_reg[DATA_W-1]}}, z_reg} - {{2{prior_reg[DATA_W-1]}}, prior_reg};
    assign pp_mcand    = {2'b00, pp_reg};
    assign one_minus_k = GAIN_ONE - k_reg;
    assign div_start   = (state_reg == S_DIVGO);
    assign mul_start   = (state_reg == S_MULGO);

    assign est_sum   = {{(PROD_W-DATA_W){prior_reg[DATA_W-1]}}, prior_reg} + delta;
    assign est_hi    = !est_sum[PROD_W-1] && (est_sum[PROD_W-2:DATA_W-1] != '0);
    assign est_lo    = est_sum[PROD_W-1] && (est_sum[PROD_W-2:DATA_W-1] != '1);
    assign est_clamp = est_hi ? S32_MAX : (est_lo ? S32_MIN : est_sum[DATA_W-1:0]);

    skf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .p_prior  (pp_reg),
        .r_noise  (r_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    skf_mul u_mul_est (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (mul_start),
        .mcand       (innov),
        .mplier      (k_reg),
        .done        (mul_e_done),
        .product_q16 (delta)
    );

    skf_mul u_mul_cov (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (mul_start),
        .mcand       (pp_mcand),
        .mplier      (one_minus_k),
        .done        (mul_p_done),
        .product_q16 (cov_prod)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_fire) state_next = S_PREP;
            S_PREP:  state_next = S_DIVGO;
            S_DIVGO: state_next = S_DIV;
            S_DIV:   if (div_done) state_next = S_MULGO;
            S_MULGO: state_next = S_MUL;
            S_MUL:   if (mul_e_done) state_next = S_FIN;
            S_FIN:   if (fin_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            q_reg         <= NOISE_RESET;
            r_reg         <= NOISE_RESET;
            est_reg       <= '0;
            cov_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_PROCESS_NOISE: q_reg <= cfg_data;
                    REG_MEASURE_NOISE: r_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (fin_go)
            begin
                est_reg       <= est_clamp;
                cov_reg       <= cov_prod[DATA_W-1:0];
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            z_reg    <= measurement;
            step_reg <= predicted_step;
        end
        if (state_reg == S_PREP)
        begin
            prior_reg <= prior_clamp;
            pp_reg    <= pp_clamp;
            sat_reg   <= prior_ovf | pp_sum[DATA_W];
        end
        if ((state_reg == S_DIV) && div_done)
        begin
            k_reg <= div_quo;
        end
        if (fin_go)
        begin
            out_est_reg  <= est_clamp;
            out_gain_reg <= k_reg;
            out_sat_reg  <= sat_reg | est_hi | est_lo;
        end
    end

    assign out_valid   = out_valid_reg;
    assign estimate    = out_est_reg;
    assign kalman_gain = out_gain_reg;
    assign saturated   = out_sat_reg;

`ifndef ASSERT_OFF
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");

    a_mul_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        mul_e_done == mul_p_done)
        else $error("multipliers out of step");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kalman_gain <= GAIN_ONE))
        else $error("gain above one");

    a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_PREP) && !in_ready)
        else $error("input beat did not start a step");
`endif

endmodule

`default_nettype wire

### hw/rtl/skf_div.sv
`default_nettype none

module skf_div
    import skf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] p_prior,
    input  wire logic [DATA_W-1:0] r_noise,
    output logic                   done,
    output logic [GAIN_W-1:0]      quotient
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DATA_W:0]     den_reg, den_next;
    logic [DATA_W+1:0]   rem_reg, rem_next;
    logic [GAIN_W-1:0]   quo_reg, quo_next;
    logic                zero_reg, zero_next;
    logic [DATA_W+2:0]   diff;
    logic                ge;
    logic [DATA_W+1:0]   rem_sel;

    assign diff    = {1'b0, rem_reg} - {2'b00, den_reg};
    assign ge      = ~diff[DATA_W+2];
    assign rem_sel = ge ? diff[DATA_W+1:0] : rem_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        zero_next = zero_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = LAST_STEP;
            den_next  = {1'b0, p_prior} + {1'b0, r_noise};
            rem_next  = {2'b00, p_prior};
            quo_next  = '0;
            zero_next = (p_prior == '0) && (r_noise == '0);
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle, restoring
            quo_next = {quo_reg[GAIN_W-2:0], ge};
            rem_next = {rem_sel[DATA_W:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        zero_reg <= zero_next;
    end

    assign done     = done_reg;
    assign quotient = zero_reg ? '0 : quo_reg;

endmodule

`default_nettype wire

### hw/rtl/skf_mul.sv
`default_nettype none

module skf_mul
    import skf_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic signed [MCAND_W-1:0] mcand,
    input  wire logic [GAIN_W-1:0]         mplier,
    output logic                           done,
    output logic signed [PROD_W-1:0]       product_q16
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic signed [MCAND_W-1:0]  b_reg, b_next;
    logic [GAIN_W-1:0]          mp_reg, mp_next;
    logic signed [MCAND_W:0]    hi_reg, hi_next;
    logic [GAIN_W-1:0]          lo_reg, lo_next;
    logic signed [MCAND_W:0]    addend;
    logic signed [MCAND_W:0]    sum;

    assign addend = mp_reg[0] ? {b_reg[MCAND_W-1], b_reg} : '0;
    assign sum    = hi_reg + addend;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        b_next    = b_reg;
        mp_next   = mp_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = LAST_STEP;
            b_next    = mcand;
            mp_next   = mplier;
            hi_next   = '0;
            lo_next   = '0;
        end
        else if (busy_reg)
        begin
            // add, then shift one bit of the product out
            hi_next  = sum >>> 1;
            lo_next  = {sum[0], lo_reg[GAIN_W-1:1]};
            mp_next  = {1'b0, mp_reg[GAIN_W-1:1]};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg  <= b_next;
        mp_reg <= mp_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign done        = done_reg;
    assign product_q16 = {hi_reg, lo_reg[GAIN_W-1]};

endmodule

`default_nettype wire
